FILE: rtl/core/m4mul_pkg.sv
// m4mul_pkg: shared widths and constants for the 4x4 matrix multiply unit
// no dependencies; imported by the channel interfaces, the core and its checker
`timescale 1ns / 1ps

package m4mul_pkg;

  // payload field widths, fixed by the channel format
  localparam int INDEX_WIDTH = 4;
  localparam int VALUE_WIDTH = 32;

  // matrix geometry
  localparam int ELEM_COUNT = 16;
  localparam int TERM_COUNT = 4;

  // factor select codes
  localparam logic SEL_LEFT  = 1'b0;
  localparam logic SEL_RIGHT = 1'b1;

  // index of the final product element
  localparam logic [INDEX_WIDTH-1:0] LAST_INDEX = 4'(ELEM_COUNT - 1);

endpackage : m4mul_pkg

FILE: rtl/core/m4mul_in_if.sv
// m4mul_in_if: element write channel, valid/ready with one element per beat
// depends on m4mul_pkg for the field widths
`timescale 1ns / 1ps

interface m4mul_in_if;
  import m4mul_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          which_matrix;
  logic [INDEX_WIDTH-1:0]        element_index;
  logic signed [VALUE_WIDTH-1:0] element_value;
  logic                          start_compute;

  modport source (
    output valid, which_matrix, element_index, element_value, start_compute,
    input  ready
  );

  modport sink (
    input  valid, which_matrix, element_index, element_value, start_compute,
    output ready
  );

endinterface : m4mul_in_if

FILE: rtl/core/m4mul_out_if.sv
// m4mul_out_if: product element channel, valid/ready with one element per beat
// depends on m4mul_pkg for the field widths
`timescale 1ns / 1ps

interface m4mul_out_if;
  import m4mul_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [INDEX_WIDTH-1:0]        result_index;
  logic signed [VALUE_WIDTH-1:0] result_value;
  logic                          last_result;

  modport source (
    output valid, result_index, result_value, last_result,
    input  ready
  );

  modport sink (
    input  valid, result_index, result_value, last_result,
    output ready
  );

endinterface : m4mul_out_if

FILE: rtl/core/matrix4_multiply_unit.sv
// matrix4_multiply_unit: 4x4 column-major fixed-point matrix product
// depends on m4mul_pkg, m4mul_in_if and m4mul_out_if
`timescale 1ns / 1ps

// Usage
//   feed beats each write one element (which_matrix, element_index,
//   element_value) into the left or right factor store. A beat with
//   start_compute set writes its element, then the block computes
//   left*right and sends the 16 product elements on result in index
//   order (row + 4*column), last_result marking index 15.
//   Each product element is four multiply-accumulate steps through one
//   shared multiplier: four read issues, a drain of the read and multiply
//   registers, a shift and saturate, then the element waits in the output
//   register. feed.ready returns after the final element is taken.
//   feed.ready is high only while no product is in progress; result.valid
//   holds with a stable payload while the receiver stalls, and the
//   sequencer waits with it.
//   Reset (rst, synchronous) returns the sequencer to idle and drops
//   result.valid. The factor stores are not cleared: every element must be
//   written before a product that reads it is started.

module matrix4_multiply_unit #(
  parameter int ELEMENT_WIDTH = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  m4mul_in_if.sink            feed,
  m4mul_out_if.source         result
);
  import m4mul_pkg::*;

  // element width as stored, capped at the channel width
  localparam int EW = (ELEMENT_WIDTH < VALUE_WIDTH) ? ELEMENT_WIDTH : VALUE_WIDTH;
  localparam int PW = 2 * EW;
  localparam int AW = PW + 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_OUT
  } state_t;

  state_t                 state;
  logic [1:0]             term;
  logic [INDEX_WIDTH-1:0] elem;
  logic                   rd_vld;
  logic                   prod_vld;

  logic signed [EW-1:0]   left_mem  [ELEM_COUNT];
  logic signed [EW-1:0]   right_mem [ELEM_COUNT];
  logic signed [EW-1:0]   rd_left;
  logic signed [EW-1:0]   rd_right;
  logic signed [PW-1:0]   prod;
  logic signed [AW-1:0]   acc;

  logic [INDEX_WIDTH-1:0]        out_index;
  logic signed [VALUE_WIDTH-1:0] out_value;
  logic                          out_last;

  logic                   feed_beat;
  logic                   result_beat;
  logic [INDEX_WIDTH-1:0] left_addr;
  logic [INDEX_WIDTH-1:0] right_addr;
  logic signed [AW-1:0]   shifted;
  logic [AW-EW:0]         top_bits;
  logic signed [EW-1:0]   sat_value;

  assign feed_beat   = feed.valid && feed.ready;
  assign result_beat = result.valid && result.ready;

  assign feed.ready          = (state == S_IDLE);
  assign result.valid        = (state == S_OUT);
  assign result.result_index = out_index;
  assign result.result_value = out_value;
  assign result.last_result  = out_last;

  // operand addresses: left (row, term), right (term, column)
  assign left_addr  = {term, elem[1:0]};
  assign right_addr = {elem[3:2], term};

  // factor stores, write on feed beat, registered read
  always_ff @(posedge clk) begin
    if (feed_beat) begin
      if (feed.which_matrix == SEL_RIGHT) begin
        right_mem[feed.element_index] <= feed.element_value[EW-1:0];
      end else begin
        left_mem[feed.element_index] <= feed.element_value[EW-1:0];
      end
    end
    rd_left  <= left_mem[left_addr];
    rd_right <= right_mem[right_addr];
  end

  // scale down and saturate the finished sum
  always_comb begin
    shifted  = acc >>> FRACTION_BITS;
    top_bits = shifted[AW-1:EW-1];
    if ((&top_bits) || !(|top_bits)) begin
      sat_value = shifted[EW-1:0];
    end else if (shifted[AW-1]) begin
      sat_value = {1'b1, {(EW-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(EW-1){1'b1}}};
    end
  end

  // sequencer, multiply-accumulate pipeline and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      term     <= '0;
      elem     <= '0;
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      rd_vld   <= (state == S_ISSUE);
      prod_vld <= rd_vld;
      unique case (state)
        S_IDLE: begin
          if (feed_beat && feed.start_compute) begin
            state <= S_ISSUE;
            term  <= '0;
            elem  <= '0;
          end
        end
        S_ISSUE: begin
          term <= term + 2'd1;
          if (term == 2'(TERM_COUNT - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_vld && !prod_vld) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (result_beat) begin
            term <= '0;
            if (out_last) begin
              state <= S_IDLE;
            end else begin
              state <= S_ISSUE;
              elem  <= elem + 4'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end

    // payload path, no reset needed
    prod <= rd_left * rd_right;
    if ((state == S_IDLE) || (state == S_OUT)) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + AW'(prod);
    end
    if ((state == S_DRAIN) && !rd_vld && !prod_vld) begin
      out_index <= elem;
      out_value <= VALUE_WIDTH'(sat_value);
      out_last  <= (elem == LAST_INDEX);
    end
  end

endmodule : matrix4_multiply_unit

FILE: rtl/core/m4mul_checker.sv
// m4mul_checker: port-level assertions for matrix4_multiply_unit
// depends on m4mul_pkg; bound to matrix4_multiply_unit at the end of this file
`timescale 1ns / 1ps

module m4mul_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               feed_valid,
  input logic                               feed_ready,
  input logic                               feed_start,
  input logic                               result_valid,
  input logic                               result_ready,
  input logic [m4mul_pkg::INDEX_WIDTH-1:0]  result_index,
  input logic                               result_last
);
  import m4mul_pkg::*;

  // the block never takes writes while a product element waits on result
  a_busy_excl: assert property (@(posedge clk) disable iff (rst)
    !(feed_ready && result_valid))
    else $error("feed ready while a product element is pending");

  // a start beat locks out further writes
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (feed_valid && feed_ready && feed_start) |=> !feed_ready)
    else $error("feed ready right after a start beat");

  // last marker only on the final index
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_last) |-> (result_index == LAST_INDEX))
    else $error("last_result on an index other than the final one");

  // mid-product beat keeps the block busy
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && !result_last) |=> !feed_ready)
    else $error("feed ready before the final product element");

  // last beat ends the product
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && result_last) |=> !result_valid)
    else $error("result still valid after the final beat");

endmodule : m4mul_checker

bind matrix4_multiply_unit m4mul_checker u_m4mul_checker (
  .clk          (clk),
  .rst          (rst),
  .feed_valid   (feed.valid),
  .feed_ready   (feed.ready),
  .feed_start   (feed.start_compute),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_index (result.result_index),
  .result_last  (result.last_result)
);

FILE: tb/testbench.sv
// testbench: self-checking bench for matrix4_multiply_unit with random element writes
// depends on m4mul_pkg, m4mul_in_if, m4mul_out_if and the unit itself
`timescale 1ns / 1ps

module testbench;
  import m4mul_pkg::*;

  localparam int FRAC_BITS   = 16;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 200;
  localparam int LONG_HOLD   = 400;

  localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = 32'sh7fffffff;
  localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = 32'sh80000000;
  localparam logic signed [65:0] SUM_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SUM_MIN = -66'sd2147483648;

  typedef struct {
    logic                          which;
    logic [INDEX_WIDTH-1:0]        index;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          start;
  } elem_write_t;

  typedef struct {
    logic [INDEX_WIDTH-1:0]        index;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          last;
  } product_elem_t;

  logic clk;
  logic rst;

  m4mul_in_if  feed_bus ();
  m4mul_out_if result_bus ();

  matrix4_multiply_unit #(
    .ELEMENT_WIDTH (VALUE_WIDTH),
    .FRACTION_BITS (FRAC_BITS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed_bus),
    .result (result_bus)
  );

  // factor stores as the unit should hold them
  logic signed [VALUE_WIDTH-1:0] left_store  [ELEM_COUNT];
  logic signed [VALUE_WIDTH-1:0] right_store [ELEM_COUNT];

  elem_write_t   write_queue[$];
  product_elem_t product_queue[$];

  int cycle_count;
  int mismatches;
  int writes_accepted;
  int products_started;
  int beats_checked;
  int sat_count;

  int feed_gap;
  int feed_calm;
  int sink_stall;
  int sink_calm;
  int long_hold;
  bit long_hold_done;

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst                      = 1'b1;
    feed_bus.valid           = 1'b0;
    feed_bus.which_matrix    = SEL_LEFT;
    feed_bus.element_index   = '0;
    feed_bus.element_value   = '0;
    feed_bus.start_compute   = 1'b0;
    result_bus.ready         = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // one product element: four products summed exactly, floored shift, saturate
  function automatic logic signed [VALUE_WIDTH-1:0] dot_element(int row, int col);
    logic signed [65:0] acc;
    logic signed [65:0] shifted;
    longint             prod;
    acc = '0;
    for (int t = 0; t < TERM_COUNT; t++) begin
      prod = longint'(left_store[row + 4 * t]) * longint'(right_store[t + 4 * col]);
      acc  = acc + 66'(prod);
    end
    shifted = acc >>> FRAC_BITS;
    if (shifted > SUM_MAX) begin
      sat_count++;
      return VALUE_MAX;
    end
    if (shifted < SUM_MIN) begin
      sat_count++;
      return VALUE_MIN;
    end
    return shifted[VALUE_WIDTH-1:0];
  endfunction

  // store an accepted element and, on a start beat, queue the whole product
  function automatic void apply_write(elem_write_t w);
    product_elem_t p;
    if (w.which == SEL_RIGHT) right_store[w.index] = w.value;
    else left_store[w.index] = w.value;
    writes_accepted++;
    if (w.start) begin
      products_started++;
      for (int k = 0; k < ELEM_COUNT; k++) begin
        p.index = INDEX_WIDTH'(k);
        p.value = dot_element(k % 4, k / 4);
        p.last  = (p.index == LAST_INDEX);
        product_queue.push_back(p);
      end
    end
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // element values: mostly small Q16.16, some full range and some extremes
  function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return VALUE_WIDTH'(int'($urandom_range(0, 524288)) - 262144);
    if (sel < 7) return $urandom;
    if (sel < 8) return VALUE_WIDTH'(int'($urandom_range(0, 33554432)) - 16777216);
    case ($urandom_range(0, 4))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      2:       return '0;
      3:       return '1;
      default: return 1;
    endcase
  endfunction

  task automatic queue_write(logic which, int index, logic signed [VALUE_WIDTH-1:0] value,
                             logic start);
    elem_write_t w;
    w.which = which;
    w.index = INDEX_WIDTH'(index);
    w.value = value;
    w.start = start;
    write_queue.push_back(w);
  endtask

  task automatic wait_drained();
    while (write_queue.size() != 0 || product_queue.size() != 0) @(posedge clk);
  endtask

  // feed driver: holds each beat until accepted, then takes a random gap
  always @(posedge clk) begin
    if (rst) begin
      feed_bus.valid <= 1'b0;
      feed_gap  = 0;
      feed_calm = 0;
    end else begin
      if (feed_bus.valid && feed_bus.ready) begin
        apply_write(write_queue.pop_front());
        if (feed_calm > 0) begin
          feed_calm--;
          feed_gap = 0;
        end else begin
          feed_gap = pick_gap();
          if ($urandom_range(0, 30) == 0) feed_calm = $urandom_range(20, 60);
        end
      end
      if (!feed_bus.valid || feed_bus.ready) begin
        if (feed_gap > 0) begin
          feed_gap--;
          feed_bus.valid <= 1'b0;
        end else if (write_queue.size() != 0) begin
          feed_bus.valid         <= 1'b1;
          feed_bus.which_matrix  <= write_queue[0].which;
          feed_bus.element_index <= write_queue[0].index;
          feed_bus.element_value <= write_queue[0].value;
          feed_bus.start_compute <= write_queue[0].start;
        end else begin
          feed_bus.valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off while the sender keeps offering beats
  always @(posedge clk) begin
    if (rst) begin
      long_hold      <= 0;
      long_hold_done <= 1'b0;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
    end else if (!long_hold_done && beats_checked >= 200) begin
      long_hold      <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end
  end

  // result monitor and ready generator
  always @(posedge clk) begin : result_side
    product_elem_t want;
    if (rst) begin
      result_bus.ready <= 1'b0;
      sink_stall     = 0;
      sink_calm      = 0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (product_queue.size() == 0) begin
          $error("unexpected result beat: index %0d value %0d",
                 result_bus.result_index, result_bus.result_value);
          mismatches++;
        end else begin
          want = product_queue.pop_front();
          if (result_bus.result_index !== want.index) begin
            $error("result_index: expected %0d, got %0d", want.index, result_bus.result_index);
            mismatches++;
          end
          if (result_bus.result_value !== want.value) begin
            $error("result_value: expected %0d, got %0d", want.value, result_bus.result_value);
            mismatches++;
          end
          if (result_bus.last_result !== want.last) begin
            $error("last_result: expected %0b, got %0b", want.last, result_bus.last_result);
            mismatches++;
          end
        end
        beats_checked++;
      end
      if (long_hold > 0) begin
        result_bus.ready <= 1'b0;
      end else if (sink_stall > 0) begin
        sink_stall--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
        if (sink_calm > 0) begin
          sink_calm--;
        end else if ($urandom_range(0, 3) == 0) begin
          sink_stall = pick_gap();
          if ($urandom_range(0, 20) == 0) sink_calm = $urandom_range(30, 100);
        end
      end
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    int remaining;
    int run_len;
    @(negedge rst);

    // load both factors with small values, start on the final write
    for (int i = 0; i < ELEM_COUNT; i++)
      queue_write(SEL_LEFT, i, VALUE_WIDTH'(int'($urandom_range(0, 131072)) - 65536), 1'b0);
    for (int i = 0; i < ELEM_COUNT; i++)
      queue_write(SEL_RIGHT, i, VALUE_WIDTH'(int'($urandom_range(0, 131072)) - 65536),
                  i == ELEM_COUNT - 1);

    // directed: saturation both ways, floored rounding, zero, index extremes
    queue_write(SEL_LEFT,  0, VALUE_MAX, 1'b0);
    queue_write(SEL_RIGHT, 0, VALUE_MAX, 1'b1);
    queue_write(SEL_LEFT,  0, VALUE_MIN, 1'b1);
    queue_write(SEL_RIGHT, 15, '1, 1'b0);
    queue_write(SEL_LEFT,  15, 1, 1'b1);
    queue_write(SEL_LEFT,  0, '0, 1'b0);
    queue_write(SEL_RIGHT, 0, '0, 1'b1);
    queue_write(SEL_RIGHT, 15, VALUE_MAX, 1'b1);
    queue_write(SEL_LEFT,  15, VALUE_MIN, 1'b1);
    queue_write(SEL_LEFT,  3, VALUE_MAX, 1'b0);
    queue_write(SEL_LEFT,  7, VALUE_MAX, 1'b0);
    queue_write(SEL_LEFT,  11, VALUE_MAX, 1'b1);
    queue_write(SEL_RIGHT, 12, VALUE_MIN, 1'b0);
    queue_write(SEL_RIGHT, 13, VALUE_MIN, 1'b1);

    // sender pauses until every product element has come back
    wait_drained();

    // random: short write runs closed by a start, a few bare starts
    for (int half = 0; half < 2; half++) begin
      remaining = 167;
      while (remaining > 0) begin
        run_len = $urandom_range(0, 12);
        if (run_len >= remaining) run_len = remaining - 1;
        for (int j = 0; j < run_len; j++)
          queue_write(1'($urandom_range(0, 1)), $urandom_range(0, 15), pick_value(), 1'b0);
        queue_write(1'($urandom_range(0, 1)), $urandom_range(0, 15), pick_value(), 1'b1);
        remaining -= run_len + 1;
      end
      wait_drained();
    end

    repeat (SETTLE) @(posedge clk);
    if (product_queue.size() != 0) begin
      $error("%0d product elements never arrived", product_queue.size());
      mismatches++;
    end
    $display("run covered %0d element writes and %0d products", writes_accepted,
             products_started);
    $display("%0d result beats checked, %0d saturated elements predicted", beats_checked,
             sat_count);
    if (mismatches == 0) begin
      $display("[matrix4_multiply_unit] OK");
    end else begin
      $display("[matrix4_multiply_unit] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", cycle_count);
    $display("[matrix4_multiply_unit] ERROR");
    $finish;
  end

  initial begin
    cycle_count      = 0;
    mismatches       = 0;
    writes_accepted  = 0;
    products_started = 0;
    beats_checked    = 0;
    sat_count        = 0;
  end

endmodule : testbench

FILE: matrix4_multiply_unit.f
rtl/core/m4mul_pkg.sv
rtl/core/m4mul_in_if.sv
rtl/core/m4mul_out_if.sv
rtl/core/matrix4_multiply_unit.sv
rtl/core/m4mul_checker.sv
tb/testbench.sv
